// ----- rtl/core/cubic_bezier_point_generator_unit_macros.svh -----
// assertion macros for the cubic bezier point generator checker
// expects clk and rst_n in the scope where the macros are used
`ifndef CUBIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CBPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CBPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- rtl/core/cbpg_pkg.sv -----
// shared types and constants for the cubic bezier point generator
// no dependencies
package cbpg_pkg;

    localparam int COORD_W = 12;
    localparam int IDX_W   = 6;
    localparam int T_W     = 17;
    localparam int WT_W    = 49;
    localparam int PROD_W  = 62;
    localparam int SUM_W   = 64;
    localparam int FRAC_W  = 48;

    localparam logic [T_W-1:0]   T_ONE      = 17'h10000;
    localparam logic [T_W-1:0]   STEP_RESET = 17'd5898;
    localparam logic [IDX_W-1:0] IDX_MAX    = 6'd62;

    typedef logic signed [COORD_W-1:0] coord_t;

    // control points of one curve
    typedef struct packed {
        coord_t [3:0] x;
        coord_t [3:0] y;
    } pts_t;

    // per-sample control traveling with the data
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
    } tag_t;

    // sample issued by the sequencer
    typedef struct packed {
        tag_t           tag;
        logic [T_W-1:0] t;
        pts_t           pts;
    } samp_t;

    // bernstein weights of one sample
    typedef struct packed {
        tag_t                 tag;
        logic [3:0][WT_W-1:0] w;
        pts_t                 pts;
    } wts_t;

endpackage

// ----- rtl/core/cbpg_seq.sv -----
// sample sequencer: holds the step register and walks t across one curve
// depends on cbpg_pkg
module cbpg_seq
    import cbpg_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           cfg_we,
    input  logic [T_W-1:0] cfg_data,
    input  pts_t           pts_in,
    output samp_t          samp
);

    logic [T_W-1:0]   step_reg;
    logic             active_reg;
    logic             active_next;
    logic [T_W-1:0]   t_reg;
    logic [T_W-1:0]   t_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    pts_t             pts_reg;
    pts_t             pts_next;
    logic [T_W:0]     t_adv;
    logic             last_w;
    logic             accept;

    // end of curve: index cap reached or next t would pass 1.0
    assign t_adv  = {1'b0, t_reg} + {1'b0, step_reg};
    assign last_w = (idx_reg == IDX_MAX) || (t_adv > {1'b0, T_ONE});
    assign busy   = active_reg & ~last_w;
    assign accept = start & ~busy;

    // next state
    always_comb
    begin
        active_next = active_reg;
        t_next      = t_reg;
        idx_next    = idx_reg;
        pts_next    = pts_reg;
        if (accept)
        begin
            active_next = 1'b1;
            t_next      = '0;
            idx_next    = '0;
            pts_next    = pts_in;
        end
        else if (active_reg)
        begin
            if (last_w)
            begin
                active_next = 1'b0;
            end
            else
            begin
                t_next   = t_adv[T_W-1:0];
                idx_next = idx_reg + 6'd1;
            end
        end
    end

    // control and step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= STEP_RESET;
        end
        else
        begin
            active_reg <= active_next;
            if (cfg_we)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        idx_reg <= idx_next;
        pts_reg <= pts_next;
    end

    assign samp.tag.valid = active_reg;
    assign samp.tag.idx   = idx_reg;
    assign samp.tag.last  = last_w;
    assign samp.t         = t_reg;
    assign samp.pts       = pts_reg;

endmodule

// ----- rtl/core/cbpg_weight.sv -----
// two-stage weight unit: u^3, 3u^2t, 3ut^2, t^3 with u = 1 - t in q1.16
// depends on cbpg_pkg
module cbpg_weight
    import cbpg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  samp_t samp,
    output wts_t  wts
);

    logic [T_W-1:0]     u_w;
    logic [T_W+1:0]     t3_w;
    logic [T_W+1:0]     u3_w;
    logic [2*T_W-1:0]   tt_w;
    logic [2*T_W-1:0]   uu_w;

    tag_t               tag1_reg;
    logic [T_W-1:0]     t1_reg;
    logic [T_W-1:0]     u1_reg;
    logic [T_W+1:0]     t3_reg;
    logic [T_W+1:0]     u3_reg;
    logic [2*T_W-1:0]   tt_reg;
    logic [2*T_W-1:0]   uu_reg;
    pts_t               pts1_reg;

    logic [3*T_W-1:0]   w0_w;
    logic [3*T_W+1:0]   w1_w;
    logic [3*T_W+1:0]   w2_w;
    logic [3*T_W-1:0]   w3_w;

    tag_t               tag2_reg;
    logic [3:0][WT_W-1:0] w_reg;
    pts_t               pts2_reg;

    // stage 1: complement, squares and triples
    assign u_w  = T_ONE - samp.t;
    assign t3_w = {2'b00, samp.t} + {1'b0, samp.t, 1'b0};
    assign u3_w = {2'b00, u_w} + {1'b0, u_w, 1'b0};
    assign tt_w = samp.t * samp.t;
    assign uu_w = u_w * u_w;

    // stage 2: cubic weights, each at most 2^48
    assign w0_w = uu_reg * u1_reg;
    assign w1_w = uu_reg * t3_reg;
    assign w2_w = tt_reg * u3_reg;
    assign w3_w = tt_reg * t1_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= samp.tag;
            tag2_reg <= tag1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        t1_reg   <= samp.t;
        u1_reg   <= u_w;
        t3_reg   <= t3_w;
        u3_reg   <= u3_w;
        tt_reg   <= tt_w;
        uu_reg   <= uu_w;
        pts1_reg <= samp.pts;
        w_reg[0] <= w0_w[WT_W-1:0];
        w_reg[1] <= w1_w[WT_W-1:0];
        w_reg[2] <= w2_w[WT_W-1:0];
        w_reg[3] <= w3_w[WT_W-1:0];
        pts2_reg <= pts1_reg;
    end

    assign wts.tag = tag2_reg;
    assign wts.w   = w_reg;
    assign wts.pts = pts2_reg;

endmodule

// ----- rtl/core/cbpg_comb.sv -----
// four-stage combiner: weighted coordinate products, adder tree, truncation
// depends on cbpg_pkg
module cbpg_comb
    import cbpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  wts_t   wts,
    output tag_t   tag,
    output coord_t x,
    output coord_t y
);

    logic signed [PROD_W-1:0] xp_w [4];
    logic signed [PROD_W-1:0] yp_w [4];
    logic signed [PROD_W-1:0] xp_reg [4];
    logic signed [PROD_W-1:0] yp_reg [4];
    logic signed [PROD_W:0]   x01_reg;
    logic signed [PROD_W:0]   x23_reg;
    logic signed [PROD_W:0]   y01_reg;
    logic signed [PROD_W:0]   y23_reg;
    logic signed [SUM_W-1:0]  xs_reg;
    logic signed [SUM_W-1:0]  ys_reg;
    coord_t                   x_reg;
    coord_t                   y_reg;
    tag_t                     tag3_reg;
    tag_t                     tag4_reg;
    tag_t                     tag5_reg;
    tag_t                     tag6_reg;

    // divide by 2^48 rounding toward zero
    function automatic coord_t trunc_coord(input logic signed [SUM_W-1:0] s);
        logic rnd;
        rnd = s[SUM_W-1] & (|s[FRAC_W-1:0]);
        return s[FRAC_W+COORD_W-1:FRAC_W] + {{(COORD_W-1){1'b0}}, rnd};
    endfunction

    // stage 3: weight times coordinate, one multiplier per term and axis
    for (genvar i = 0; i < 4; i++)
    begin : g_term
        assign xp_w[i] = $signed({1'b0, wts.w[i]}) * $signed(wts.pts.x[i]);
        assign yp_w[i] = $signed({1'b0, wts.w[i]}) * $signed(wts.pts.y[i]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end
        else
        begin
            tag3_reg <= wts.tag;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag5_reg;
        end
    end

    // payload: products, pair sums, full sum, truncated result
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            xp_reg[i] <= xp_w[i];
            yp_reg[i] <= yp_w[i];
        end
        x01_reg <= (PROD_W+1)'(xp_reg[0]) + (PROD_W+1)'(xp_reg[1]);
        x23_reg <= (PROD_W+1)'(xp_reg[2]) + (PROD_W+1)'(xp_reg[3]);
        y01_reg <= (PROD_W+1)'(yp_reg[0]) + (PROD_W+1)'(yp_reg[1]);
        y23_reg <= (PROD_W+1)'(yp_reg[2]) + (PROD_W+1)'(yp_reg[3]);
        xs_reg  <= SUM_W'(x01_reg) + SUM_W'(x23_reg);
        ys_reg  <= SUM_W'(y01_reg) + SUM_W'(y23_reg);
        x_reg   <= trunc_coord(xs_reg);
        y_reg   <= trunc_coord(ys_reg);
    end

    assign tag = tag6_reg;
    assign x   = x_reg;
    assign y   = y_reg;

endmodule

// ----- rtl/core/cubic_bezier_point_generator_unit.sv -----
// cubic bezier point generator: one curve transaction in, sampled points out
// points: once accepted, a curve's samples come out in order, one per cycle
// throughput: busy stays high until the sample sequencer issues the last t of a curve, so a
//   new curve is taken with that last t; the sequencer issues one t per cycle into a
//   6-stage pipeline
// reset: asynchronous, active low; clears valid bits and sets the step to 5898
// depends on cbpg_pkg, cbpg_seq, cbpg_weight, cbpg_comb
module cubic_bezier_point_generator_unit
    import cbpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [T_W-1:0]   cfg_data,
    input  coord_t           p0_x,
    input  coord_t           p0_y,
    input  coord_t           p1_x,
    input  coord_t           p1_y,
    input  coord_t           p2_x,
    input  coord_t           p2_y,
    input  coord_t           p3_x,
    input  coord_t           p3_y,
    output logic             result_valid,
    output coord_t           curve_x,
    output coord_t           curve_y,
    output logic [IDX_W-1:0] sample_index,
    output logic             last_sample
);

    pts_t  pts_in;
    samp_t samp;
    wts_t  wts;
    tag_t  tag;

    // gather control points
    assign pts_in.x[0] = p0_x;
    assign pts_in.x[1] = p1_x;
    assign pts_in.x[2] = p2_x;
    assign pts_in.x[3] = p3_x;
    assign pts_in.y[0] = p0_y;
    assign pts_in.y[1] = p1_y;
    assign pts_in.y[2] = p2_y;
    assign pts_in.y[3] = p3_y;

    cbpg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .pts_in   (pts_in),
        .samp     (samp)
    );

    cbpg_weight u_weight (
        .clk   (clk),
        .rst_n (rst_n),
        .samp  (samp),
        .wts   (wts)
    );

    cbpg_comb u_comb (
        .clk   (clk),
        .rst_n (rst_n),
        .wts   (wts),
        .tag   (tag),
        .x     (curve_x),
        .y     (curve_y)
    );

    assign result_valid = tag.valid;
    assign sample_index = tag.idx;
    assign last_sample  = tag.last;

endmodule

// ----- rtl/core/cbpg_checker.sv -----
// port-level checker for the cubic bezier point generator, bound to the top level
// depends on cbpg_pkg and cubic_bezier_point_generator_unit_macros.svh
`include "cubic_bezier_point_generator_unit_macros.svh"

module cbpg_checker
    import cbpg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input logic [IDX_W-1:0] sample_index,
    input logic             last_sample
);

    // samples of one curve arrive back to back with rising index
    `CBPG_ASSERT_NEXT(a_idx_step, result_valid && !last_sample, (result_valid && sample_index == $past(sample_index) + 6'd1), "sample index did not advance")

    // after the last sample only a new curve can follow
    `CBPG_ASSERT_NEXT(a_after_last, result_valid && last_sample, (!result_valid || sample_index == 6'd0), "point after last sample is not a new curve")

    // a curve never runs past the sample cap
    `CBPG_ASSERT_NOW(a_idx_cap, result_valid && sample_index == IDX_MAX, last_sample, "sample cap reached without last flag")

    // accepted transaction shows its first point after the pipeline latency
    `CBPG_ASSERT_NOW(a_latency, start && !busy, ##7 (result_valid && sample_index == 6'd0), "first point missing after accept")

endmodule

bind cubic_bezier_point_generator_unit cbpg_checker u_checker (.*);

// ----- sim/tb_cubic_bezier_point_generator_unit.sv -----
// self-checking testbench for cubic_bezier_point_generator_unit
// depends on cbpg_pkg and the rtl of the point generator; needs no other files
module tb_cubic_bezier_point_generator_unit
    import cbpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_TAIL = 12;
    localparam int unsigned END_LIMIT  = 5000;
    localparam int unsigned PHASES     = 10;
    localparam int unsigned PHASE_LEN  = 39;

    // one sampled point as it leaves the block
    typedef struct packed {
        coord_t           x;
        coord_t           y;
        logic [IDX_W-1:0] idx;
        logic             last;
    } curve_point_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             cfg_we;
    logic [T_W-1:0]   cfg_data;
    coord_t           p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic             result_valid;
    coord_t           curve_x;
    coord_t           curve_y;
    logic [IDX_W-1:0] sample_index;
    logic             last_sample;

    // points still owed by the block, oldest first
    curve_point_t     pending_points[$];
    logic [T_W-1:0]   model_step;
    int unsigned      mismatch_count = 0;

    cubic_bezier_point_generator_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .p0_x         (p0_x),
        .p0_y         (p0_y),
        .p1_x         (p1_x),
        .p1_y         (p1_y),
        .p2_x         (p2_x),
        .p2_y         (p2_y),
        .p3_x         (p3_x),
        .p3_y         (p3_y),
        .result_valid (result_valid),
        .curve_x      (curve_x),
        .curve_y      (curve_y),
        .sample_index (sample_index),
        .last_sample  (last_sample)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one coordinate of the curve at t, exact sum then truncation toward zero
    function automatic coord_t bezier_axis(input int unsigned t, input coord_t c0,
                                           input coord_t c1, input coord_t c2,
                                           input coord_t c3);
        longint tt;
        longint uu;
        longint acc;
        tt  = longint'(t);
        uu  = longint'(T_ONE) - tt;
        acc = uu * uu * uu * longint'(c0)
            + 3 * uu * uu * tt * longint'(c1)
            + 3 * uu * tt * tt * longint'(c2)
            + tt * tt * tt * longint'(c3);
        return coord_t'(acc / (longint'(1) << FRAC_W));
    endfunction

    // number of samples for a step, capped at the index range
    function automatic int unsigned samples_for_step(input logic [T_W-1:0] step);
        int unsigned n;
        int unsigned cap;
        cap = int'(IDX_MAX) + 1;
        if (step == '0)
            n = cap;
        else
            n = int'(T_ONE) / int'(step) + 1;
        if (n > cap)
            n = cap;
        return n;
    endfunction

    // queue every point that one curve transaction produces
    function automatic void predict_curve_points(input pts_t pts);
        int unsigned  n;
        curve_point_t pt;
        n = samples_for_step(model_step);
        for (int unsigned k = 0; k < n; k++)
        begin
            pt.x    = bezier_axis(k * model_step, pts.x[0], pts.x[1], pts.x[2], pts.x[3]);
            pt.y    = bezier_axis(k * model_step, pts.y[0], pts.y[1], pts.y[2], pts.y[3]);
            pt.idx  = IDX_W'(k);
            pt.last = (k + 1 == n);
            pending_points.push_back(pt);
        end
    endfunction

    function automatic pts_t curve_of(input coord_t x0, input coord_t x1, input coord_t x2,
                                      input coord_t x3, input coord_t y0, input coord_t y1,
                                      input coord_t y2, input coord_t y3);
        pts_t pts;
        pts.x[0] = x0;
        pts.x[1] = x1;
        pts.x[2] = x2;
        pts.x[3] = x3;
        pts.y[0] = y0;
        pts.y[1] = y1;
        pts.y[2] = y2;
        pts.y[3] = y3;
        return pts;
    endfunction

    // mostly uniform, sometimes a corner value
    function automatic coord_t random_coord();
        if ($urandom_range(0, 9) < 8)
            return coord_t'($urandom_range(0, 4095));
        case ($urandom_range(0, 4))
            0: return -12'sd2048;
            1: return -12'sd1;
            2: return 12'sd0;
            3: return 12'sd1;
            default: return 12'sd2047;
        endcase
    endfunction

    function automatic pts_t random_curve();
        return curve_of(random_coord(), random_coord(), random_coord(), random_coord(),
                        random_coord(), random_coord(), random_coord(), random_coord());
    endfunction

    // half back to back, otherwise short or medium gaps and a few long pauses
    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // present one curve after gap idle cycles; returns on the accepting edge
    task automatic send_curve(input pts_t pts, input int unsigned gap);
        logic taken;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        p0_x  <= pts.x[0];
        p1_x  <= pts.x[1];
        p2_x  <= pts.x[2];
        p3_x  <= pts.x[3];
        p0_y  <= pts.y[0];
        p1_y  <= pts.y[1];
        p2_y  <= pts.y[2];
        p3_y  <= pts.y[3];
        // busy is stable mid-cycle, so it tells what the next edge does
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            if (taken)
                predict_curve_points(pts);
            @(posedge clk);
        end
    endtask

    // stop sending and wait until every owed point has come out
    task automatic settle_block();
        start <= 1'b0;
        while (pending_points.size() > 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // write the step register while the block is idle
    task automatic program_step(input logic [T_W-1:0] step);
        settle_block();
        cfg_we   <= 1'b1;
        cfg_data <= step;
        @(posedge clk);
        cfg_we     <= 1'b0;
        model_step  = step;
    endtask

    task automatic report_field(input string field, input int expd, input int act);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, expd, act);
        mismatch_count++;
    endtask

    // compare each point transaction with the oldest expectation
    always @(negedge clk)
    begin : check_points
        curve_point_t want;
        if (rst_n && result_valid)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t ns: unexpected point, expected none, actual x %0d y %0d idx %0d",
                         $time, curve_x, curve_y, sample_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (curve_x !== want.x)
                    report_field("curve_x", int'(want.x), int'(curve_x));
                if (curve_y !== want.y)
                    report_field("curve_y", int'(want.y), int'(curve_y));
                if (sample_index !== want.idx)
                    report_field("sample_index", int'(want.idx), int'(sample_index));
                if (last_sample !== want.last)
                    report_field("last_sample", int'(want.last), int'(last_sample));
            end
        end
    end

    // corner shapes at the reset step, including truncation of negative values
    task automatic test_directed_shapes();
        send_curve(curve_of(0, 0, 0, 0, 0, 0, 0, 0), 2);
        send_curve(curve_of(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047), 0);
        send_curve(curve_of(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048), 0);
        send_curve(curve_of(-2048, 2047, -2048, 2047, 2047, -2048, 2047, -2048), 3);
        send_curve(curve_of(12'sh555, 12'shAAA, 12'sh555, 12'shAAA,
                            12'shAAA, 12'sh555, 12'shAAA, 12'sh555), 0);
        send_curve(curve_of(-2048, -683, 682, 2047, 2047, 682, -683, -2048), 1);
        send_curve(curve_of(0, 2047, 2047, 0, 0, -2048, -2048, 0), 0);
        send_curve(curve_of(-1, 1, -1, 1, 1, -1, 0, -1), 5);
        send_curve(curve_of(-1, -1, -1, 0, 0, 0, 1, -1), 0);
    endtask

    // zero step, smallest steps, the 63-sample boundary, one and above one
    task automatic test_step_extremes();
        logic [T_W-1:0] steps[9];
        steps = '{17'd0, 17'd1, 17'd1040, 17'd1041, 17'd65535, 17'd65536, 17'd65537,
                  17'd131071, STEP_RESET};
        foreach (steps[i])
        begin
            program_step(steps[i]);
            send_curve(random_curve(), $urandom_range(0, 2));
        end
    endtask

    // random curves over several steps, with a full drain at each phase start and one mid-phase
    task automatic test_random_curves();
        logic [T_W-1:0] step;
        int unsigned    drain_at;
        logic           quiet;
        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            case (ph == 0 ? 0 : ph == 1 ? 1 : $urandom_range(2, 9))
                0: step = T_W'($urandom_range(0, 1040));
                1: step = T_W'($urandom_range(65537, 131071));
                2: step = T_W'(int'(T_ONE) / $urandom_range(1, 62));
                default: step = T_W'($urandom_range(1041, 65536));
            endcase
            program_step(step);
            quiet    = (ph % 4 == 2);
            drain_at = $urandom_range(5, PHASE_LEN - 5);
            for (int unsigned i = 0; i < PHASE_LEN; i++)
            begin
                if (i == drain_at)
                    settle_block();
                send_curve(random_curve(), quiet ? 0 : random_gap());
            end
        end
    endtask

    initial
    begin : run_tests
        int unsigned waited;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_data   <= '0;
        p0_x       <= '0;
        p0_y       <= '0;
        p1_x       <= '0;
        p1_y       <= '0;
        p2_x       <= '0;
        p2_y       <= '0;
        p3_x       <= '0;
        p3_y       <= '0;
        model_step  = STEP_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_shapes();
        test_step_extremes();
        test_random_curves();

        // let the last curves finish
        start <= 1'b0;
        waited = 0;
        while (pending_points.size() > 0 && waited < END_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_points.size() > 0)
        begin
            $display("%0t ns: %0d points never came out", $time, pending_points.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #5_000_000;
        $display("%0t ns: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
